@@ rtl/rtti_pkg.sv @@
// Shared types and constants of the radix text-to-integer parser.
package rtti_pkg;

	localparam int VALUE_BITS_DEFAULT = 53;
	localparam int RADIX_W            = 6;
	localparam int CHAR_W             = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_LO_Z  = 8'h7a;
	localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_RADIX = 2'd1,
		ST_BAD_DIGIT = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic               blank;
		logic               is_digit;
		logic [RADIX_W-1:0] digit;
	} char_class_t;

endpackage

@@ rtl/rtti_decode.sv @@
// Character classifier: blank detection and digit value of one character.
module rtti_decode (
	input  logic [rtti_pkg::CHAR_W-1:0] character,
	output rtti_pkg::char_class_t       cls
);

	logic [rtti_pkg::CHAR_W-1:0] value;

	always_comb begin
		value = '0;
		cls.blank = (character == rtti_pkg::CHAR_SPACE) || (character == rtti_pkg::CHAR_TAB);
		cls.is_digit = 1'b1;
		priority if (character >= rtti_pkg::CHAR_ZERO && character <= rtti_pkg::CHAR_NINE) begin
			value = character - rtti_pkg::CHAR_ZERO;
		end else if (character >= rtti_pkg::CHAR_UP_A && character <= rtti_pkg::CHAR_UP_Z) begin
			value = character - rtti_pkg::CHAR_UP_A + rtti_pkg::LETTER_BASE;
		end else if (character >= rtti_pkg::CHAR_LO_A && character <= rtti_pkg::CHAR_LO_Z) begin
			value = character - rtti_pkg::CHAR_LO_A + rtti_pkg::LETTER_BASE;
		end else begin
			cls.is_digit = 1'b0;
		end
		cls.digit = value[rtti_pkg::RADIX_W-1:0];
	end

endmodule

@@ rtl/rtti_parse.sv @@
// Parser state: phase, accumulator and first error, updated once per item.
module rtti_parse #(
	parameter int VALUE_BITS = rtti_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic                         last,
	input  rtti_pkg::char_class_t        cls,
	input  logic [rtti_pkg::RADIX_W-1:0] radix,
	output logic [VALUE_BITS-1:0]        result_value,
	output rtti_pkg::status_t            result_status
);

	localparam int EXT_W = VALUE_BITS + rtti_pkg::RADIX_W;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_TRAIL  = 3'b100
	} phase_t;

	phase_t                phase_q, phase_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	rtti_pkg::status_t     err_q, err_d;

	logic             radix_bad;
	logic             digit_bad;
	logic             take;
	logic [EXT_W-1:0] sum;
	logic             overflow;

	assign radix_bad = (radix < rtti_pkg::RADIX_MIN) || (radix > rtti_pkg::RADIX_MAX);
	assign digit_bad = !cls.is_digit || (cls.digit >= radix);
	assign sum = EXT_W'(acc_q) * EXT_W'(radix) + EXT_W'(cls.digit);
	assign overflow = |sum[EXT_W-1:VALUE_BITS];

	always_comb begin
		phase_d = phase_q;
		acc_d = acc_q;
		err_d = err_q;
		take = 1'b0;
		if (radix_bad) begin
			err_d = rtti_pkg::ST_BAD_RADIX;
		end else if (err_q != rtti_pkg::ST_BAD_RADIX) begin
			unique case (phase_q)
				PH_DIGITS: begin
					if (cls.blank) begin
						phase_d = PH_TRAIL;
					end else begin
						take = 1'b1;
					end
				end
				PH_TRAIL: begin
					if (!cls.blank && err_q == rtti_pkg::ST_OK) begin
						err_d = rtti_pkg::ST_BAD_DIGIT;
					end
				end
				default: begin
					if (!cls.blank) begin
						phase_d = PH_DIGITS;
						take = 1'b1;
					end
				end
			endcase
		end
		if (take && err_q == rtti_pkg::ST_OK) begin
			priority if (digit_bad) begin
				err_d = rtti_pkg::ST_BAD_DIGIT;
			end else if (overflow) begin
				err_d = rtti_pkg::ST_OVERFLOW;
			end else begin
				acc_d = sum[VALUE_BITS-1:0];
			end
		end
	end

	assign result_value = (err_d == rtti_pkg::ST_OK) ? acc_d : '0;
	assign result_status = err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			acc_q <= '0;
			err_q <= rtti_pkg::ST_OK;
		end else if (fire) begin
			if (last) begin
				phase_q <= PH_LEAD;
				acc_q <= '0;
				err_q <= rtti_pkg::ST_OK;
			end else begin
				phase_q <= phase_d;
				acc_q <= acc_d;
				err_q <= err_d;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> phase_q == PH_LEAD && acc_q == '0 && err_q == rtti_pkg::ST_OK)
		else $error("parser state not cleared after the last item of a string");

	a_lead_acc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEAD |-> acc_q == '0)
		else $error("accumulator nonzero before the first digit");

	a_error_freezes_acc: assert property (@(posedge clk) disable iff (!arst_n)
		err_q != rtti_pkg::ST_OK && !(fire && last) |=> $stable(acc_q))
		else $error("accumulator changed after an error was latched");

endmodule

@@ rtl/radix_text_to_integer_core.sv @@
// Top level of the radix text-to-integer parser with stream ports and radix register.
// The block takes one character per cycle and, on the character marked tlast, gives one
// item with the parsed value in tdata and the status in tuser (0 ok, 1 bad radix,
// 2 bad digit, 3 overflow; the value is 0 unless the status is ok). A character is held
// in an input register and parsed there; the accumulator update (one multiply by the
// radix, an add of the digit and an overflow check) is combinational; the result
// goes to the output register when the last character leaves the input register.
// A new character is taken in every cycle, except that a last character waiting in the
// input register holds the input for as long as the previous result is not taken. The
// radix register may be written only while no string is in progress.
module radix_text_to_integer_core #(
	parameter int VALUE_BITS = rtti_pkg::VALUE_BITS_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rtti_pkg::RADIX_W-1:0]      cfg_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rtti_pkg::CHAR_W-1:0]       s_tdata,   // character
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [((VALUE_BITS+7)/8)*8-1:0]   m_tdata,   // value, zero padded
	output logic [1:0]                        m_tuser    // status
);

	localparam int OUT_DATA_W = ((VALUE_BITS + 7) / 8) * 8;

	logic [rtti_pkg::RADIX_W-1:0] radix_q;
	logic                         valid_s1;
	logic [rtti_pkg::CHAR_W-1:0]  char_s1;
	logic                         last_s1;
	logic                         fire_s1;
	logic                         load_out;
	rtti_pkg::char_class_t        cls;
	logic [VALUE_BITS-1:0]        result_value;
	rtti_pkg::status_t            result_status;
	logic [VALUE_BITS-1:0]        value_q;
	rtti_pkg::status_t            status_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rtti_pkg::RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	assign fire_s1 = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || fire_s1;
	assign load_out = fire_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	rtti_decode u_decode (
		.character (char_s1),
		.cls       (cls)
	);

	rtti_parse #(
		.VALUE_BITS (VALUE_BITS)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire_s1),
		.last          (last_s1),
		.cls           (cls),
		.radix         (radix_q),
		.result_value  (result_value),
		.result_status (result_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load_out) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q <= result_value;
			status_q <= result_status;
		end
	end

	assign m_tdata = OUT_DATA_W'(value_q);
	assign m_tuser = status_q;

endmodule
